// ===== rtl/core/completion_slot_table_macros.svh =====
// assertion helpers
`ifndef COMPLETION_SLOT_TABLE_MACROS_SVH
`define COMPLETION_SLOT_TABLE_MACROS_SVH
`define CST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CST_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/core/cst_pkg.sv =====
package cst_pkg;
	localparam int SLOTS = 64;
	localparam int VALUE_BYTES = 8;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int ID_W = 7;
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		CMD_ALLOC = 3'd0, CMD_WBYTE = 3'd1, CMD_WBYTES = 3'd2, CMD_POST = 3'd3,
		CMD_TAKEV = 3'd4, CMD_TAKEE = 3'd5, CMD_STATUS = 3'd6, CMD_NONE = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FREE = 2'd0, ST_WAIT = 2'd1, ST_READY = 2'd2, ST_ERROR = 2'd3
	} slot_st_t;

	localparam logic [0:0] REG_OVERSIZE = 1'b0;
	localparam logic [0:0] REG_INVALID = 1'b1;

	// classified command as it travels from front to back
	typedef struct packed {
		cmd_t cmd;
		logic known;
		logic [IDX_W-1:0] idx;
		logic [ID_W-1:0] id;
		logic [3:0] vsize;
		logic [3:0] count;
		logic [63:0] data;
		logic [15:0] err;
	} cmd_item_t;

	typedef struct packed {
		logic push;
		logic full;
		logic pop;
		logic empty;
	} q_ctl_t;
endpackage

// ===== rtl/core/cst_front.sv =====
module cst_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [2:0] command,
	input logic [6:0] slot_id,
	input logic [3:0] value_size,
	input logic [3:0] byte_count,
	input logic [63:0] data,
	input logic [15:0] error_in,
	input logic pop,
	output logic busy,
	output logic q_valid,
	output cst_pkg::cmd_item_t q_item
);
	import cst_pkg::*;
	cmd_item_t q_mem_q [QDEPTH];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_item_t it;
	q_ctl_t ctl;

	always_comb begin
		it.cmd = cmd_t'(command);
		it.known = (slot_id >= 7'd1) && (slot_id <= 7'(SLOTS));
		it.idx = it.known ? IDX_W'(slot_id - 7'd1) : '0;
		it.id = slot_id;
		it.vsize = (value_size > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES) : value_size;
		it.count = byte_count;
		it.data = data;
		it.err = error_in;
	end

	assign busy = (cnt_q == 2'(QDEPTH));
	assign ctl.full = busy;
	assign ctl.empty = (cnt_q == 2'd0);
	assign ctl.push = start && !ctl.full;
	assign ctl.pop = pop && !ctl.empty;
	assign q_valid = !ctl.empty;
	assign q_item = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (ctl.push) q_mem_q[wp_q] <= it;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (ctl.push) wp_q <= wp_q + 1'b1;
			if (ctl.pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(ctl.push) - 2'(ctl.pop);
		end
	end
endmodule

// ===== rtl/core/cst_back.sv =====
module cst_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input cst_pkg::cmd_item_t q_item,
	input logic [15:0] oversize_code,
	input logic [15:0] invalid_code,
	output logic pop,
	output logic done,
	output logic ok,
	output logic [6:0] slot_out,
	output logic [1:0] status,
	output logic [63:0] value_out,
	output logic [15:0] error_out
);
	import cst_pkg::*;
	// per-slot state lives in flops (free scan needs all); payload in memories
	slot_st_t st_q [SLOTS];
	logic [3:0] left_mem [SLOTS];
	logic [3:0] pos_mem [SLOTS];
	logic [63:0] val_mem [SLOTS];
	logic [15:0] err_mem [SLOTS];

	typedef enum logic [1:0] {PH_RD = 2'b01, PH_EX = 2'b10} ph_t;
	ph_t ph_q;
	cmd_item_t it_q;
	logic [3:0] left_q, pos_q;
	logic [63:0] val_q;
	logic [15:0] err_q;

	logic found;
	logic [IDX_W-1:0] free_idx;
	always_comb begin
		found = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (st_q[i] == ST_FREE) begin
				found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign pop = (ph_q == PH_RD) && q_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			it_q <= q_item;
			left_q <= left_mem[q_item.idx];
			pos_q <= pos_mem[q_item.idx];
			val_q <= val_mem[q_item.idx];
			err_q <= err_mem[q_item.idx];
		end
	end

	// execute-phase computation
	slot_st_t cur, nst;
	logic [3:0] nleft, npos;
	logic [63:0] nval, mask;
	logic [15:0] nerr;
	logic wr, r_ok;
	logic [6:0] r_slot;
	logic [1:0] r_st;
	logic [63:0] r_val;
	logic [15:0] r_err;
	logic [IDX_W-1:0] widx;
	logic [5:0] shamt;

	always_comb begin
		cur = it_q.known ? st_q[it_q.idx] : ST_FREE;
		nst = cur; nleft = left_q; npos = pos_q; nval = val_q; nerr = err_q;
		wr = 1'b0; r_ok = 1'b0; r_slot = it_q.id; r_val = '0; r_err = '0;
		widx = it_q.idx;
		mask = '0; shamt = '0;
		unique case (it_q.cmd)
			CMD_ALLOC: begin
				r_slot = '0;
				if (it_q.vsize != 4'd0 && found) begin
					widx = free_idx; wr = 1'b1;
					nst = ST_WAIT; nleft = it_q.vsize; npos = '0; nval = '0; nerr = '0;
					r_slot = 7'(free_idx) + 7'd1; r_ok = 1'b1;
				end
			end
			CMD_WBYTE: begin
				if (it_q.known && cur == ST_WAIT) begin
					wr = 1'b1; r_ok = 1'b1;
					if (pos_q < 4'd8) begin
						shamt = {pos_q[2:0], 3'b000};
						nval = (val_q & ~(64'hFF << shamt)) | ({56'd0, it_q.data[7:0]} << shamt);
					end
					npos = pos_q + 4'd1;
					nleft = left_q - 4'd1;
					if (nleft == 4'd0) nst = ST_READY;
				end
			end
			CMD_WBYTES: begin
				if (it_q.known && cur == ST_WAIT) begin
					wr = 1'b1;
					if (it_q.count > left_q) begin
						nerr = oversize_code; nst = ST_ERROR;
					end else begin
						r_ok = 1'b1;
						// bytes land at pos..pos+count-1, never past byte 7 since
						// pos + left never exceeds the armed size
						for (int k = 0; k < 8; k++) begin
							if (4'(k) < it_q.count) mask[k*8 +: 8] = 8'hFF;
						end
						if (pos_q < 4'd8) begin
							shamt = {pos_q[2:0], 3'b000};
							nval = (val_q & ~(mask << shamt)) | ((it_q.data & mask) << shamt);
						end
						npos = pos_q + it_q.count;
						nleft = left_q - it_q.count;
						if (nleft == 4'd0) nst = ST_READY;
					end
				end
			end
			CMD_POST: begin
				if (it_q.known && it_q.err != 16'd0 && cur == ST_WAIT) begin
					wr = 1'b1; nerr = it_q.err; nst = ST_ERROR; r_ok = 1'b1;
				end
			end
			CMD_TAKEV: begin
				if (it_q.known && cur == ST_READY) begin
					r_val = val_q; nst = ST_FREE; wr = 1'b1; r_ok = 1'b1;
				end
			end
			CMD_TAKEE: begin
				if (!it_q.known || cur == ST_FREE) r_err = invalid_code;
				else if (cur == ST_ERROR) begin
					r_err = err_q; nst = ST_FREE; wr = 1'b1; r_ok = 1'b1;
				end else if (cur == ST_READY) r_ok = 1'b1;
			end
			CMD_STATUS: r_ok = it_q.known;
			default: ;
		endcase
		r_st = (r_slot != 7'd0 && r_slot <= 7'(SLOTS)) ? (wr ? nst : cur) : ST_FREE;
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_EX && wr) begin
			left_mem[widx] <= nleft;
			pos_mem[widx] <= npos;
			val_mem[widx] <= nval;
			err_mem[widx] <= nerr;
		end
		if (ph_q == PH_EX) begin
			ok <= r_ok; slot_out <= r_slot; status <= r_st;
			value_out <= r_val; error_out <= r_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_RD;
			done <= 1'b0;
			for (int i = 0; i < SLOTS; i++) st_q[i] <= ST_FREE;
		end else begin
			done <= (ph_q == PH_EX);
			unique case (ph_q)
				PH_RD: if (q_valid) ph_q <= PH_EX;
				PH_EX: begin
					ph_q <= PH_RD;
					if (wr) st_q[widx] <= nst;
				end
				default: ph_q <= PH_RD;
			endcase
		end
	end
endmodule

// ===== rtl/core/completion_slot_table.sv =====
// done and the results are registered at the end of the back end's execute phase;
// commands queued ahead are executed first, one at a time.
// The back end takes one command at a time: a read pass over the slot memories, then
// an execute pass, and only then does it pop the next command.
// The two-entry command queue raises busy when full; results cannot stall.
// Reset (arst_n low): all slots free, queue empty, codes -90 and -22.
module completion_slot_table (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] command,
	input logic [6:0] slot_id,
	input logic [3:0] value_size,
	input logic [3:0] byte_count,
	input logic [63:0] data,
	input logic signed [15:0] error_in,
	output logic done,
	output logic ok,
	output logic [6:0] slot_out,
	output logic [1:0] status,
	output logic [63:0] value_out,
	output logic signed [15:0] error_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import cst_pkg::*;
	logic [15:0] over_q, inv_q;
	logic pop, q_valid;
	cmd_item_t q_item;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_q <= 16'hFFA6; inv_q <= 16'hFFEA;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_OVERSIZE) over_q <= pwdata[15:0];
			else inv_q <= pwdata[15:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00)
			prdata = {16'd0, (paddr[2] == REG_INVALID) ? inv_q : over_q};
	end

	cst_front u_front (.clk, .arst_n, .start, .command, .slot_id, .value_size,
		.byte_count, .data, .error_in, .pop, .busy, .q_valid, .q_item);

	cst_back u_back (.clk, .arst_n, .q_valid, .q_item, .oversize_code(over_q),
		.invalid_code(inv_q), .pop, .done, .ok, .slot_out, .status,
		.value_out, .error_out);
endmodule

// ===== rtl/core/cst_checker.sv =====
`include "completion_slot_table_macros.svh"
module cst_checker (
	input logic clk,
	input logic arst_n,
	input logic done,
	input logic ok,
	input logic [6:0] slot_out,
	input logic [1:0] status,
	input logic pready
);
	`CST_ASSERT_NR(a_pready, clk, pready, "pready low")
	`CST_ASSERT(a_done_gap, clk, arst_n, done |=> !done, "done twice in a row")
	`CST_ASSERT(a_ok_slot, clk, arst_n, (done && ok) |-> slot_out != 7'd0, "ok with slot 0")
	`CST_ASSERT(a_none_free, clk, arst_n, (done && slot_out == 7'd0) |-> status == 2'd0,
		"status of no slot")
endmodule

bind completion_slot_table cst_checker u_cst_checker (.clk, .arst_n, .done, .ok,
	.slot_out, .status, .pready);
